// ===== sv/sgtp_pkg.sv =====
// Shared types, glass layout and segment fonts for the segment glass text printer.
// No dependencies; every other file in this block imports it.
package sgtp_pkg;

  localparam int unsigned NUM_POSITIONS = 25;
  localparam int unsigned POS_W         = 5;
  localparam int unsigned CHAR_W        = 8;
  localparam int unsigned SEG_W         = 15;

  typedef logic [POS_W-1:0]  pos_t;
  typedef logic [CHAR_W-1:0] char_t;
  typedef logic [SEG_W-1:0]  seg_mask_t;

  typedef enum logic {
    OP_BEGIN = 1'b0,
    OP_PRINT = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    CK_NONE,
    CK_D7,
    CK_D14,
    CK_DOT,
    CK_COL
  } cell_kind_t;

  // Generic segment bits
  localparam seg_mask_t SEG_A = seg_mask_t'(1) << 1;
  localparam seg_mask_t SEG_B = seg_mask_t'(1) << 2;
  localparam seg_mask_t SEG_C = seg_mask_t'(1) << 3;
  localparam seg_mask_t SEG_D = seg_mask_t'(1) << 4;
  localparam seg_mask_t SEG_E = seg_mask_t'(1) << 5;
  localparam seg_mask_t SEG_F = seg_mask_t'(1) << 6;
  localparam seg_mask_t SEG_G = seg_mask_t'(1) << 7;
  localparam seg_mask_t SEG_J = seg_mask_t'(1) << 8;
  localparam seg_mask_t SEG_K = seg_mask_t'(1) << 9;
  localparam seg_mask_t SEG_L = seg_mask_t'(1) << 10;
  localparam seg_mask_t SEG_M = seg_mask_t'(1) << 11;
  localparam seg_mask_t SEG_Q = seg_mask_t'(1) << 12;
  localparam seg_mask_t SEG_P = seg_mask_t'(1) << 13;
  localparam seg_mask_t SEG_N = seg_mask_t'(1) << 14;

  localparam seg_mask_t SEG_DOT    = SEG_A;
  localparam seg_mask_t SEG_MIDDOT = SEG_B;
  localparam seg_mask_t SEG_O6     = SEG_A | SEG_B | SEG_C | SEG_D | SEG_E | SEG_F;

  localparam char_t CH_NUL    = 8'h00;
  localparam char_t CH_DOT    = ".";
  localparam char_t CH_COLON  = ":";
  localparam char_t CH_MIDDOT = "*";
  localparam char_t CH_LOW_A  = "a";
  localparam char_t CH_LOW_Z  = "z";
  localparam char_t CASE_FOLD = 8'd32;

  typedef struct packed {
    op_t   op;
    pos_t  start_pos;
    char_t ch;
  } in_item_t;

  typedef struct packed {
    pos_t      position;
    seg_mask_t seg_mask;
    logic      written;
    logic      all_ok;
    logic      halted;
  } out_item_t;

  typedef struct packed {
    logic      found;
    seg_mask_t mask;
  } font_hit_t;

  // Fixed glass layout; positions past the glass are empty cells.
  function automatic cell_kind_t cell_kind(input pos_t p);
    cell_kind_t k;
    unique case (p)
      5'd0, 5'd1, 5'd3, 5'd5, 5'd7:                            k = CK_D7;
      5'd2, 5'd4, 5'd9, 5'd13, 5'd17, 5'd21:                   k = CK_COL;
      5'd6, 5'd11, 5'd15, 5'd19, 5'd23:                        k = CK_DOT;
      5'd8, 5'd10, 5'd12, 5'd14, 5'd16, 5'd18, 5'd20, 5'd22,
      5'd24:                                                   k = CK_D14;
      default:                                                 k = CK_NONE;
    endcase
    return k;
  endfunction

  function automatic font_hit_t font7(input char_t c);
    font_hit_t h;
    h.found = 1'b1;
    unique case (c)
      " ": h.mask = '0;
      "0": h.mask = SEG_O6;
      "1": h.mask = SEG_B | SEG_C;
      "2": h.mask = SEG_A | SEG_B | SEG_G | SEG_E | SEG_D;
      "3": h.mask = SEG_A | SEG_B | SEG_G | SEG_C | SEG_D;
      "4": h.mask = SEG_F | SEG_G | SEG_B | SEG_C;
      "5": h.mask = SEG_A | SEG_F | SEG_G | SEG_C | SEG_D;
      "6": h.mask = SEG_A | SEG_F | SEG_G | SEG_E | SEG_D | SEG_C;
      "7": h.mask = SEG_A | SEG_B | SEG_C;
      "8": h.mask = SEG_O6 | SEG_G;
      "9": h.mask = SEG_A | SEG_B | SEG_G | SEG_F | SEG_C | SEG_D;
      "A": h.mask = SEG_A | SEG_B | SEG_C | SEG_F | SEG_E | SEG_G;
      "B": h.mask = SEG_F | SEG_E | SEG_D | SEG_C | SEG_G;
      "C": h.mask = SEG_G | SEG_E | SEG_D;
      "D": h.mask = SEG_B | SEG_C | SEG_D | SEG_E | SEG_G;
      "E": h.mask = SEG_A | SEG_B | SEG_F | SEG_G | SEG_E | SEG_D;
      "F": h.mask = SEG_A | SEG_F | SEG_G | SEG_E;
      "H": h.mask = SEG_B | SEG_C | SEG_E | SEG_F | SEG_G;
      "I": h.mask = SEG_F | SEG_E;
      "J": h.mask = SEG_B | SEG_C | SEG_D;
      "L": h.mask = SEG_D | SEG_E | SEG_F;
      "O": h.mask = SEG_G | SEG_C | SEG_D | SEG_E;
      "P": h.mask = SEG_A | SEG_F | SEG_G | SEG_E | SEG_B;
      default: begin
        h.found = 1'b0;
        h.mask  = '0;
      end
    endcase
    return h;
  endfunction

  function automatic font_hit_t font14(input char_t c);
    font_hit_t h;
    h.found = 1'b1;
    unique case (c)
      " ":  h.mask = '0;
      "*":  h.mask = SEG_J | SEG_K | SEG_L | SEG_M | SEG_P | SEG_Q | SEG_N | SEG_G;
      "+":  h.mask = SEG_G | SEG_M | SEG_P | SEG_K;
      "-":  h.mask = SEG_G | SEG_M;
      "/":  h.mask = SEG_N | SEG_L;
      "\\": h.mask = SEG_J | SEG_Q;
      "|":  h.mask = SEG_K | SEG_P;
      "^":  h.mask = SEG_F | SEG_A | SEG_L;
      "=":  h.mask = SEG_A | SEG_G | SEG_M;
      ">":  h.mask = SEG_J | SEG_N;
      "<":  h.mask = SEG_L | SEG_Q;
      "?":  h.mask = SEG_A | SEG_B | SEG_G | SEG_M | SEG_E;
      "$":  h.mask = SEG_A | SEG_B | SEG_G | SEG_M | SEG_E | SEG_D | SEG_K | SEG_P;
      "#":  h.mask = SEG_O6 | SEG_G | SEG_M | SEG_K | SEG_P;
      "0":  h.mask = SEG_O6;
      "1":  h.mask = SEG_B | SEG_C | SEG_L;
      "2":  h.mask = SEG_A | SEG_B | SEG_G | SEG_M | SEG_E | SEG_D;
      "3":  h.mask = SEG_A | SEG_B | SEG_M | SEG_C | SEG_D;
      "4":  h.mask = SEG_F | SEG_G | SEG_M | SEG_B | SEG_C;
      "5":  h.mask = SEG_A | SEG_F | SEG_G | SEG_M | SEG_C | SEG_D;
      "6":  h.mask = SEG_A | SEG_F | SEG_G | SEG_M | SEG_E | SEG_D | SEG_C;
      "7":  h.mask = SEG_A | SEG_L | SEG_P;
      "8":  h.mask = SEG_O6 | SEG_G | SEG_M;
      "9":  h.mask = SEG_A | SEG_B | SEG_G | SEG_M | SEG_F | SEG_C;
      "A":  h.mask = SEG_A | SEG_B | SEG_C | SEG_E | SEG_F | SEG_G | SEG_M;
      "B":  h.mask = SEG_A | SEG_B | SEG_K | SEG_P | SEG_D | SEG_C | SEG_M;
      "C":  h.mask = SEG_A | SEG_F | SEG_E | SEG_D;
      "D":  h.mask = SEG_A | SEG_B | SEG_C | SEG_D | SEG_K | SEG_P;
      "E":  h.mask = SEG_A | SEG_F | SEG_G | SEG_M | SEG_E | SEG_D;
      "F":  h.mask = SEG_A | SEG_F | SEG_G | SEG_M | SEG_E;
      "G":  h.mask = SEG_A | SEG_C | SEG_D | SEG_E | SEG_F | SEG_M;
      "H":  h.mask = SEG_B | SEG_C | SEG_E | SEG_F | SEG_G | SEG_M;
      "I":  h.mask = SEG_A | SEG_K | SEG_P | SEG_D;
      "J":  h.mask = SEG_B | SEG_C | SEG_D | SEG_E;
      "K":  h.mask = SEG_E | SEG_F | SEG_G | SEG_L | SEG_Q;
      "L":  h.mask = SEG_D | SEG_E | SEG_F;
      "M":  h.mask = SEG_B | SEG_C | SEG_E | SEG_F | SEG_J | SEG_L;
      "N":  h.mask = SEG_B | SEG_C | SEG_Q | SEG_J | SEG_E | SEG_F;
      "O":  h.mask = SEG_O6;
      "P":  h.mask = SEG_A | SEG_B | SEG_E | SEG_F | SEG_G | SEG_M;
      "Q":  h.mask = SEG_O6 | SEG_Q;
      "R":  h.mask = SEG_A | SEG_B | SEG_E | SEG_F | SEG_G | SEG_M | SEG_Q;
      "S":  h.mask = SEG_A | SEG_C | SEG_D | SEG_J | SEG_M;
      "T":  h.mask = SEG_A | SEG_K | SEG_P;
      "U":  h.mask = SEG_B | SEG_C | SEG_D | SEG_E | SEG_F;
      "V":  h.mask = SEG_E | SEG_F | SEG_N | SEG_L;
      "W":  h.mask = SEG_B | SEG_C | SEG_Q | SEG_N | SEG_E | SEG_F;
      "X":  h.mask = SEG_J | SEG_L | SEG_Q | SEG_N;
      "Y":  h.mask = SEG_J | SEG_L | SEG_P;
      "Z":  h.mask = SEG_A | SEG_L | SEG_N | SEG_D;
      "%":  h.mask = SEG_F | SEG_C | SEG_L | SEG_N;
      default: begin
        h.found = 1'b0;
        h.mask  = '0;
      end
    endcase
    return h;
  endfunction

endpackage

// ===== sv/sgtp_if.sv =====
// Valid/ready channel interfaces for the printer's input and result streams.
// Depends on sgtp_pkg for the field widths.
interface sgtp_in_if
  import sgtp_pkg::*;
();
  logic  valid;
  logic  ready;
  op_t   op;
  pos_t  start_pos;
  char_t ch;

  modport source (output valid, op, start_pos, ch, input ready);
  modport sink   (input valid, op, start_pos, ch, output ready);
endinterface

interface sgtp_out_if
  import sgtp_pkg::*;
();
  logic      valid;
  logic      ready;
  pos_t      position;
  seg_mask_t seg_mask;
  logic      written;
  logic      all_ok;
  logic      halted;

  modport source (output valid, position, seg_mask, written, all_ok, halted, input ready);
  modport sink   (input valid, position, seg_mask, written, all_ok, halted, output ready);
endinterface

// ===== sv/segment_glass_text_printer_top.sv =====
// Top level of the segment glass text printer: input register, print core, result register.
// Depends on sgtp_pkg, sgtp_if (channel interfaces) and sgtp_print_core.
//
// Usage:
//   in_if  (sink)   : one item per transfer. op = begin loads start_pos as the print
//                     position and rearms the ok/halt flags; op = print lights one
//                     character at the current position (ch is ASCII).
//   out_if (source) : exactly one result per input item, in order: position,
//                     seg_mask (generic segment bits 1..14), written, all_ok, halted.
// Path: a result is decoded while its item is held in the input register, then loaded
//   into the result register when that register can take it (step high).
// Throughput: one item per cycle, sustained, while the receiver keeps ready high.
//   The rate is set by the single decode step between the two registers, which
//   also updates the print position for the next item in the same cycle.
// Reset (rst_n low, synchronous): both registers drain, print position goes to 0,
//   ok flag to 1, halt flag to 0.
// Stall: when the receiver holds ready low, the result register keeps its item;
//   the input register takes one more item if it was empty, then in_if.ready drops
//   until the result is taken.
module segment_glass_text_printer_top
  import sgtp_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  sgtp_in_if.sink         in_if,
  sgtp_out_if.source      out_if
);

  logic      in_valid_r, in_valid_nxt;
  in_item_t  in_item_r;
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_item_r;
  out_item_t core_result;
  logic      advance;
  logic      step;
  logic      in_ready;

  // Result register can load when empty or when its item leaves this cycle.
  assign advance  = !out_valid_r || out_if.ready;
  assign step     = in_valid_r && advance;
  assign in_ready = !in_valid_r || advance;

  always_comb begin
    in_valid_nxt  = in_ready ? in_if.valid : in_valid_r;
    out_valid_nxt = advance ? in_valid_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payloads: capture on transfer, hold otherwise.
  always_ff @(posedge clk) begin
    if (in_ready && in_if.valid) begin
      in_item_r.op        <= in_if.op;
      in_item_r.start_pos <= in_if.start_pos;
      in_item_r.ch        <= in_if.ch;
    end
    if (step) begin
      out_item_r <= core_result;
    end
  end

  sgtp_print_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .item   (in_item_r),
    .result (core_result)
  );

  assign in_if.ready     = in_ready;
  assign out_if.valid    = out_valid_r;
  assign out_if.position = out_item_r.position;
  assign out_if.seg_mask = out_item_r.seg_mask;
  assign out_if.written  = out_item_r.written;
  assign out_if.all_ok   = out_item_r.all_ok;
  assign out_if.halted   = out_item_r.halted;

  // A written result always lands on the glass.
  a_written_on_glass: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_item_r.written |-> out_item_r.position < POS_W'(NUM_POSITIONS))
    else $error("written result outside the glass");

  // Nothing is written by an item that leaves the printer halted.
  a_halt_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_item_r.halted |-> !out_item_r.written)
    else $error("write reported together with halt");

  // Unwritten results carry an empty mask; bit 0 is never a segment.
  a_mask_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !out_item_r.seg_mask[0] && (out_item_r.written || out_item_r.seg_mask == '0))
    else $error("bad segment mask");

  // Input back-pressure only comes from a stalled, full pipeline.
  a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> in_valid_r && out_valid_r && !out_if.ready)
    else $error("input stalled without a downstream stall");

endmodule

// ===== sv/sgtp_print_core.sv =====
// Print state (position, ok and halt flags) and the per-character decode.
// Depends on sgtp_pkg for layout, fonts and item structs.
module sgtp_print_core
  import sgtp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      step,
  input  in_item_t  item,
  output out_item_t result
);

  pos_t cur_pos_r, cur_pos_nxt;
  logic ok_r, ok_nxt;
  logic halt_r, halt_nxt;

  cell_kind_t kind, dig_kind;
  pos_t       dig_pos;
  logic       ran_out;
  char_t      uc;
  font_hit_t  hit;
  pos_t       pos;
  seg_mask_t  mask;
  logic       wr;
  logic       done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_pos_r <= '0;
      ok_r      <= 1'b1;
      halt_r    <= 1'b0;
    end else if (step) begin
      cur_pos_r <= cur_pos_nxt;
      ok_r      <= ok_nxt;
      halt_r    <= halt_nxt;
    end
  end

  // Next digit cell. Every separator on this glass is followed by a digit,
  // so the skip is at most one position.
  always_comb begin
    kind = cell_kind(cur_pos_r);
    if (kind == CK_D7 || kind == CK_D14) begin
      dig_pos = cur_pos_r;
      ran_out = 1'b0;
    end else begin
      dig_pos = cur_pos_r + 1'b1;
      ran_out = (cur_pos_r + 1'b1) >= POS_W'(NUM_POSITIONS);
    end
    dig_kind = cell_kind(dig_pos);
    uc = (item.ch >= CH_LOW_A && item.ch <= CH_LOW_Z) ? item.ch - CASE_FOLD : item.ch;
    hit = (dig_kind == CK_D7) ? font7(uc) : font14(uc);
  end

  always_comb begin
    cur_pos_nxt = cur_pos_r;
    ok_nxt      = ok_r;
    halt_nxt    = halt_r;
    pos         = cur_pos_r;
    mask        = '0;
    wr          = 1'b0;
    done        = 1'b0;
    priority if (item.op == OP_BEGIN) begin
      cur_pos_nxt = item.start_pos;
      ok_nxt      = 1'b1;
      halt_nxt    = item.start_pos >= POS_W'(NUM_POSITIONS);
      pos         = item.start_pos;
    end else if (item.ch == CH_NUL) begin
      // ignore
    end else if (halt_r || cur_pos_r >= POS_W'(NUM_POSITIONS)) begin
      halt_nxt = 1'b1;
    end else begin
      if (item.ch == CH_DOT) begin
        done = 1'b1;
        if (kind == CK_DOT || kind == CK_COL) begin
          mask        = SEG_DOT;
          wr          = 1'b1;
          cur_pos_nxt = cur_pos_r + 1'b1;
        end else begin
          ok_nxt = 1'b0;
        end
      end else if (item.ch == CH_COLON) begin
        done = 1'b1;
        if (kind == CK_COL) begin
          mask        = SEG_DOT | SEG_MIDDOT;
          wr          = 1'b1;
          cur_pos_nxt = cur_pos_r + 1'b1;
        end else begin
          ok_nxt = 1'b0;
        end
      end else if (item.ch == CH_MIDDOT && kind == CK_COL) begin
        done        = 1'b1;
        mask        = SEG_MIDDOT;
        wr          = 1'b1;
        cur_pos_nxt = cur_pos_r + 1'b1;
      end
      if (!done) begin
        if (ran_out) begin
          cur_pos_nxt = POS_W'(NUM_POSITIONS);
          halt_nxt    = 1'b1;
          ok_nxt      = 1'b0;
        end else begin
          if (!hit.found) begin
            ok_nxt = 1'b0;
          end
          mask        = hit.mask;
          wr          = 1'b1;
          pos         = dig_pos;
          cur_pos_nxt = dig_pos + 1'b1;
        end
      end
      if (!wr) begin
        pos = cur_pos_nxt;
      end
    end
  end

  assign result.position = pos;
  assign result.seg_mask = mask;
  assign result.written  = wr;
  assign result.all_ok   = ok_nxt;
  assign result.halted   = halt_nxt;

endmodule
